[rtl/block_rms_level_meter_unit_defines.svh]
// assertion macros for the block rms level meter
`ifndef BLOCK_RMS_LEVEL_METER_UNIT_DEFINES_SVH
`define BLOCK_RMS_LEVEL_METER_UNIT_DEFINES_SVH

// consequent checked in the same cycle
`define BRLM_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define BRLM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/brlm_pkg.sv]
// shared types and constants for the block rms level meter
`default_nettype none

package brlm_pkg;

   localparam int unsigned SAMPLE_W = 16;
   localparam int unsigned SQ_W     = 31;
   localparam int unsigned RAD_W    = 32;
   localparam int unsigned ROOT_W   = 16;
   localparam int unsigned SREM_W   = ROOT_W + 2;
   localparam int unsigned LEVEL_W  = 16;
   localparam int unsigned BYTES_W  = 32;

   localparam logic [BYTES_W-1:0] BYTE_LIMIT_RESET = {BYTES_W{1'b1}};
   localparam logic [BYTES_W-1:0] BYTES_MAX        = {BYTES_W{1'b1}};
   localparam logic [BYTES_W-1:0] BYTES_SAT_FROM   = BYTES_MAX - 32'd1;

   typedef struct packed {
      logic load;
      logic accum;
      logic div_start;
      logic div_step;
      logic sqrt_start;
      logic sqrt_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic running;
      logic end_of_block;
      logic div_last;
      logic sqrt_last;
      logic out_busy;
   } status_type;

endpackage

`default_nettype wire

[rtl/block_rms_level_meter_unit.sv]
// top level of the block rms level meter
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_sample, req_last_of_block
//   rsp      out        rsp_valid/rsp_stall  rsp_level, rsp_bytes_total, rsp_limit_reached
//   csr      in         csr_wr_en            csr_wr_data (byte limit)
//
// a sample that does not end a block passes the load, accumulate and decide states
// before the next acceptance, and once stopped it leaves the accumulate state unsummed
// a block end adds the shift divider (one quotient bit a cycle) and the square root
// the result register lets the next item in while a result waits on rsp_stall
// synchronous reset clears the sums, the byte total and the stop flag
`default_nettype none

module block_rms_level_meter_unit #(
   parameter int unsigned BLOCK_MAX = 512
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic signed [brlm_pkg::SAMPLE_W-1:0] req_sample,
   input  wire logic                                req_last_of_block,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [brlm_pkg::LEVEL_W-1:0]             rsp_level,
   output logic [brlm_pkg::BYTES_W-1:0]             rsp_bytes_total,
   output logic                                     rsp_limit_reached,
   input  wire logic                                csr_wr_en,
   input  wire logic [brlm_pkg::BYTES_W-1:0]        csr_wr_data
);

   brlm_pkg::cmd_type    cmd;
   brlm_pkg::status_type status;

   brlm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status_i  (status),
      .cmd_o     (cmd)
   );

   brlm_dp #(
      .BLOCK_MAX (BLOCK_MAX)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_sample        (req_sample),
      .req_last_of_block (req_last_of_block),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_level         (rsp_level),
      .rsp_bytes_total   (rsp_bytes_total),
      .rsp_limit_reached (rsp_limit_reached),
      .cmd_i             (cmd),
      .status_o          (status)
   );

endmodule

`default_nettype wire

[rtl/brlm_ctrl.sv]
// sequencing state machine for the block rms level meter
`default_nettype none

module brlm_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire brlm_pkg::status_type status_i,
   output brlm_pkg::cmd_type        cmd_o
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_ACC    = 3'd1;
   localparam logic [2:0] ST_DECIDE = 3'd2;
   localparam logic [2:0] ST_DIV    = 3'd3;
   localparam logic [2:0] ST_SQLOAD = 3'd4;
   localparam logic [2:0] ST_SQRT   = 3'd5;
   localparam logic [2:0] ST_FINISH = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      cmd_o    = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_o.load = 1'b1;
               state_in   = ST_ACC;
            end
         end
         ST_ACC: begin
            if (status_i.running) begin
               cmd_o.accum = 1'b1;
               state_in    = ST_DECIDE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DECIDE: begin
            if (status_i.end_of_block) begin
               cmd_o.div_start = 1'b1;
               state_in        = ST_DIV;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DIV: begin
            cmd_o.div_step = 1'b1;
            if (status_i.div_last) begin
               state_in = ST_SQLOAD;
            end
         end
         ST_SQLOAD: begin
            cmd_o.sqrt_start = 1'b1;
            state_in         = ST_SQRT;
         end
         ST_SQRT: begin
            cmd_o.sqrt_step = 1'b1;
            if (status_i.sqrt_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!status_i.out_busy) begin
               cmd_o.out_load = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

[rtl/brlm_dp.sv]
// accumulators, shift divider, digit square root and result register
`default_nettype none
`include "block_rms_level_meter_unit_defines.svh"

module brlm_dp #(
   parameter int unsigned BLOCK_MAX = 512
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic signed [brlm_pkg::SAMPLE_W-1:0] req_sample,
   input  wire logic                                req_last_of_block,
   input  wire logic                                csr_wr_en,
   input  wire logic [brlm_pkg::BYTES_W-1:0]        csr_wr_data,
   input  wire logic                                rsp_stall,
   output logic                                     rsp_valid,
   output logic [brlm_pkg::LEVEL_W-1:0]             rsp_level,
   output logic [brlm_pkg::BYTES_W-1:0]             rsp_bytes_total,
   output logic                                     rsp_limit_reached,
   input  wire brlm_pkg::cmd_type                   cmd_i,
   output brlm_pkg::status_type                     status_o
);

   localparam int unsigned CNT_W  = $clog2(BLOCK_MAX + 1);
   localparam int unsigned SUM_W  = brlm_pkg::SQ_W - 1 + CNT_W;
   localparam int unsigned STEP_W = $clog2(SUM_W);

   logic signed [2*brlm_pkg::SAMPLE_W-1:0] prod_sq;

   logic [brlm_pkg::SQ_W-1:0]    sq_ff;
   logic                         last_ff;
   logic [SUM_W-1:0]             sum_ff, sum_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic [brlm_pkg::BYTES_W-1:0] byte_count_ff, byte_count_in;
   logic [brlm_pkg::BYTES_W-1:0] byte_limit_ff;
   logic                         running_ff, running_in;
   logic                         hit;

   logic [SUM_W-1:0]             dvd_ff, dvd_in;
   logic [CNT_W:0]               rem_ff, rem_in, rem_sh;
   logic [STEP_W-1:0]            step_ff, step_in;

   logic [brlm_pkg::RAD_W-1:0]   rad_ff, rad_in;
   logic [brlm_pkg::SREM_W-1:0]  srem_ff, srem_in, srem_sh, trial;
   logic [brlm_pkg::ROOT_W-1:0]  root_ff, root_in;

   logic                         rsp_valid_ff;
   logic [brlm_pkg::LEVEL_W-1:0] level_ff;
   logic [brlm_pkg::BYTES_W-1:0] bytes_ff;
   logic                         limit_ff;

   assign prod_sq = (2*brlm_pkg::SAMPLE_W)'(req_sample) * (2*brlm_pkg::SAMPLE_W)'(req_sample);
   assign hit     = (byte_count_ff > byte_limit_ff);

   assign status_o.running      = running_ff;
   assign status_o.end_of_block = last_ff || (count_ff == CNT_W'(BLOCK_MAX));
   assign status_o.div_last     = (step_ff == STEP_W'(SUM_W - 1));
   assign status_o.sqrt_last    = (step_ff == STEP_W'(brlm_pkg::ROOT_W - 1));
   assign status_o.out_busy     = rsp_valid_ff && rsp_stall;

   assign rem_sh  = {rem_ff[CNT_W-1:0], dvd_ff[SUM_W-1]};
   assign srem_sh = {srem_ff[brlm_pkg::SREM_W-3:0], rad_ff[brlm_pkg::RAD_W-1 -: 2]};
   assign trial   = {root_ff, 2'b01};

   // accumulation and block bookkeeping
   always_comb begin
      sum_in        = sum_ff;
      count_in      = count_ff;
      byte_count_in = byte_count_ff;
      running_in    = running_ff;
      if (cmd_i.accum) begin
         sum_in   = sum_ff + SUM_W'(sq_ff);
         count_in = count_ff + CNT_W'(1);
         if (byte_count_ff >= brlm_pkg::BYTES_SAT_FROM) begin
            byte_count_in = brlm_pkg::BYTES_MAX;
         end else begin
            byte_count_in = byte_count_ff + 32'd2;
         end
      end
      if (cmd_i.out_load) begin
         sum_in     = '0;
         count_in   = '0;
         running_in = running_ff && !hit;
      end
   end

   // restoring divider and digit square root share the step counter
   always_comb begin
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      step_in = step_ff;
      rad_in  = rad_ff;
      srem_in = srem_ff;
      root_in = root_ff;
      if (cmd_i.div_start) begin
         dvd_in  = sum_ff;
         rem_in  = '0;
         step_in = '0;
      end else if (cmd_i.div_step) begin
         step_in = step_ff + STEP_W'(1);
         if (rem_sh >= {1'b0, count_ff}) begin
            rem_in = rem_sh - {1'b0, count_ff};
            dvd_in = {dvd_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            dvd_in = {dvd_ff[SUM_W-2:0], 1'b0};
         end
      end else if (cmd_i.sqrt_start) begin
         rad_in  = {1'b0, dvd_ff[brlm_pkg::SQ_W-1:0]};
         srem_in = '0;
         root_in = '0;
         step_in = '0;
      end else if (cmd_i.sqrt_step) begin
         step_in = step_ff + STEP_W'(1);
         rad_in  = {rad_ff[brlm_pkg::RAD_W-3:0], 2'b00};
         if (srem_sh >= trial) begin
            srem_in = srem_sh - trial;
            root_in = {root_ff[brlm_pkg::ROOT_W-2:0], 1'b1};
         end else begin
            srem_in = srem_sh;
            root_in = {root_ff[brlm_pkg::ROOT_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff        <= '0;
         count_ff      <= '0;
         byte_count_ff <= '0;
         running_ff    <= 1'b1;
         byte_limit_ff <= brlm_pkg::BYTE_LIMIT_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         sum_ff        <= sum_in;
         count_ff      <= count_in;
         byte_count_ff <= byte_count_in;
         running_ff    <= running_in;
         if (csr_wr_en) begin
            byte_limit_ff <= csr_wr_data;
         end
         if (cmd_i.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_i.load) begin
         sq_ff   <= prod_sq[brlm_pkg::SQ_W-1:0];
         last_ff <= req_last_of_block;
      end
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      step_ff <= step_in;
      rad_ff  <= rad_in;
      srem_ff <= srem_in;
      root_ff <= root_in;
      if (cmd_i.out_load) begin
         level_ff <= root_ff;
         bytes_ff <= byte_count_ff;
         limit_ff <= hit;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_level         = level_ff;
   assign rsp_bytes_total   = bytes_ff;
   assign rsp_limit_reached = limit_ff;

   `BRLM_ASSERT_SAME(a_div_nonzero, cmd_i.div_start, count_ff != '0, "divide by zero count")
   `BRLM_ASSERT_SAME(a_mean_fits, cmd_i.sqrt_start, (dvd_ff >> brlm_pkg::SQ_W) == '0, "mean too wide")
   `BRLM_ASSERT_NEXT(a_stop_holds, !running_ff, !running_ff, "recording restarted without reset")
   `BRLM_ASSERT_NEXT(a_bytes_mono, 1'b1, byte_count_ff >= $past(byte_count_ff), "byte total fell")

endmodule

`default_nettype wire
